// ===== hdl/uart_frame_rx_deframer_top_assert.svh =====
// Assertion macros for the deframer
`ifndef UART_FRAME_RX_DEFRAMER_TOP_ASSERT_SVH
`define UART_FRAME_RX_DEFRAMER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define UFD_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define UFD_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`else
`define UFD_ASSERT_IMPL(lbl, a, c)
`define UFD_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// ===== hdl/ufd_pkg.sv =====
package ufd_pkg;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] TIMEOUT_RESET = 8'd100;
  localparam logic [7:0] PRE1_RESET = 8'hC9;
  localparam logic [7:0] PRE2_RESET = 8'hE7;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned MIN_LEN = 3;
  localparam int unsigned HDR_BYTES = 5;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_PRE1    = 2'd1,
    REG_PRE2    = 2'd2
  } reg_idx_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] x;
    x = c ^ d;
    for (int b = 0; b < 8; b++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction
endpackage

// ===== hdl/uart_frame_rx_deframer_top.sv =====
// Channel | dir | tdata fields (low bit up)                      | tuser
// s_axis  | in  | rx_byte[7:0], line_error[8]                    | kind
// m_axis  | out | msg_code, data_byte, has_data, data_index,     | -
//         |     | crc/overflow/line-error counts                 |
//         |     | (tlast = last)                                 |
// apb     | cfg | 0 timeout, 1 preamble first, 2 preamble second | -
// One item at a time: the item is accepted, then each scan pass checks the
// buffer, searches for a preamble, reads the length, runs the CRC and emits
// the results; a dropped preamble starts another pass, so one item can take
// several passes over the buffer. The buffer is a circular memory with a head
// pointer; dropping bytes moves the head. Reset clears control state only.
// Output stalls hold the sequencer.
`include "uart_frame_rx_deframer_top_assert.svh"
module uart_frame_rx_deframer_top #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // rx_byte[7:0], line_error[8]
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // msg_code, data_byte, has_data, data_index,
                                     // crc_error_count, overflow_count, line_error_count
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [7:0] MAX_LEN = 8'(BUFFER_DEPTH - 2);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SRD, S_SCMP, S_HDR, S_HCHK, S_CRD, S_CCMP,
    S_DRD, S_EMIT
  } state_t;

  state_t state;
  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] head;
  logic [CW-1:0] fill;
  logic oflag;
  logic [7:0] ticks, last_t, tmo, pre1, pre2;
  logic [15:0] crc_tot, ovf_tot, le_tot;
  logic [CW-1:0] idx;    // scan offset from head
  logic [7:0] prev;      // previous byte in search
  logic [7:0] len, code, crc;
  logic [6:0] nres;
  logic [5:0] didx;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, o};
    if (s >= (CW+1)'(BUFFER_DEPTH)) s = s - (CW+1)'(BUFFER_DEPTH);
    return s[AW-1:0];
  endfunction

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      ufd_pkg::REG_TIMEOUT: prdata = {24'd0, tmo};
      ufd_pkg::REG_PRE1:    prdata = {24'd0, pre1};
      ufd_pkg::REG_PRE2:    prdata = {24'd0, pre2};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) rdata <= mem[raddr];

  assign s_axis_tready = (state == S_IDLE);
  wire expired = (8'(ticks - last_t) >= tmo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; head <= '0; fill <= '0; oflag <= 1'b0;
      ticks <= '0; last_t <= '0; crc_tot <= '0; ovf_tot <= '0; le_tot <= '0;
      tmo <= ufd_pkg::TIMEOUT_RESET; pre1 <= ufd_pkg::PRE1_RESET;
      pre2 <= ufd_pkg::PRE2_RESET; m_axis_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          ufd_pkg::REG_TIMEOUT: tmo <= pwdata[7:0];
          ufd_pkg::REG_PRE1:    pre1 <= pwdata[7:0];
          ufd_pkg::REG_PRE2:    pre2 <= pwdata[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          nres <= '0;
          if (!s_axis_tuser) begin
            last_t <= ticks;
            if (s_axis_tdata[8]) begin
              le_tot <= le_tot + 16'd1; oflag <= 1'b1;
            end else if (fill < DEPTH_C) begin
              mem[wrap(head, fill)] <= s_axis_tdata[7:0];
              fill <= fill + CW'(1);
            end else begin
              oflag <= 1'b1; ovf_tot <= ovf_tot + 16'd1;
            end
          end else ticks <= ticks + 8'd1;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (oflag) begin
            fill <= '0; oflag <= 1'b0; state <= S_IDLE;
          end else if (fill > CW'(1)) begin
            idx <= '0; raddr <= head; state <= S_SRD;
          end else state <= S_IDLE;
        end
        S_SRD: begin
          raddr <= wrap(head, idx + CW'(1)); idx <= idx + CW'(1); state <= S_SCMP;
        end
        S_SCMP: begin
          // rdata is byte at idx-1
          if (idx > CW'(1) && prev == pre1 && rdata == pre2) begin
            head <= wrap(head, idx - CW'(2)); fill <= fill - (idx - CW'(2));
            state <= S_HDR;
          end else if (idx == fill) begin
            // no preamble: keep only last byte
            head <= wrap(head, fill - CW'(1)); fill <= CW'(1); state <= S_IDLE;
          end else begin
            prev <= rdata;
            raddr <= wrap(head, idx + CW'(1)); idx <= idx + CW'(1);
          end
        end
        S_HDR: begin
          if (fill >= CW'(ufd_pkg::HDR_BYTES)) begin
            raddr <= wrap(head, CW'(2)); state <= S_HCHK; idx <= '0;
          end else if (expired) begin
            head <= wrap(head, CW'(2)); fill <= fill - CW'(2); state <= S_CHECK;
          end else state <= S_IDLE;
        end
        S_HCHK: begin
          // wait for the registered read, then read length
          if (idx == '0) begin
            idx <= CW'(1); raddr <= wrap(head, CW'(3));
          end else begin
            len <= rdata;
            if (rdata < 8'(ufd_pkg::MIN_LEN) || rdata > MAX_LEN) begin
              head <= wrap(head, CW'(2)); fill <= fill - CW'(2); state <= S_CHECK;
            end else if ({1'b0, fill} < (CW+1)'(rdata) + (CW+1)'(2)) begin
              if (expired) begin
                head <= wrap(head, CW'(2)); fill <= fill - CW'(2); state <= S_CHECK;
              end else state <= S_IDLE;
            end else begin
              crc <= '0; idx <= CW'(2); raddr <= wrap(head, CW'(2)); state <= S_CRD;
            end
          end
        end
        S_CRD: begin
          raddr <= wrap(head, idx + CW'(1)); state <= S_CCMP;
        end
        S_CCMP: begin
          if (idx == CW'(3)) code <= rdata;
          if (idx == CW'(len) + CW'(1)) begin
            if (crc == rdata) begin
              if ({2'b00, nres} + {1'b0, (len == 8'd3) ? 8'd1 : len - 8'd3} >
                  9'(ufd_pkg::MAX_RESULTS))
                state <= S_IDLE;
              else begin
                didx <= '0; idx <= CW'(4); raddr <= wrap(head, CW'(4)); state <= S_DRD;
              end
            end else begin
              crc_tot <= crc_tot + 16'd1;
              head <= wrap(head, CW'(2)); fill <= fill - CW'(2); state <= S_CHECK;
            end
          end else begin
            crc <= ufd_pkg::crc8_byte(crc, rdata);
            idx <= idx + CW'(1); raddr <= wrap(head, idx + CW'(2));
          end
        end
        S_DRD: begin
          if (!m_axis_tvalid || m_axis_tready) state <= S_EMIT;
          if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
        end
        S_EMIT: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tlast <= (len == 8'd3) || (idx == CW'(len));
          m_axis_tdata <= {1'b0, le_tot, ovf_tot, crc_tot, didx,
                           (len != 8'd3), (len == 8'd3) ? 8'd0 : rdata, code};
          nres <= nres + 7'd1;
          if ((len == 8'd3) || (idx == CW'(len))) begin
            head <= wrap(head, CW'(len) + CW'(2));
            fill <= fill - (CW'(len) + CW'(2));
            state <= S_CHECK;
          end else begin
            didx <= didx + 6'd1; idx <= idx + CW'(1);
            raddr <= wrap(head, idx + CW'(1)); state <= S_DRD;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_DRD && m_axis_tvalid && m_axis_tready && state != S_EMIT)
        m_axis_tvalid <= 1'b0;
    end
  end

  `UFD_ASSERT_IMPL(a_fill_bound, 1'b1, fill <= DEPTH_C)
  `UFD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready && state != S_EMIT, m_axis_tvalid)
  `UFD_ASSERT_IMPL(a_ready_idle, s_axis_tready, state == S_IDLE)
endmodule

// ===== test/tb_uart_frame_rx_deframer_top.sv =====
module tb_uart_frame_rx_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int SETTLE_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam bit KIND_BYTE = 1'b0;
  localparam bit KIND_TICK = 1'b1;

  typedef struct packed {
    logic [7:0]  code;
    logic [7:0]  data;
    logic        has;
    logic [5:0]  idx;
    logic        last;
    logic [15:0] crc_cnt;
    logic [15:0] ovf_cnt;
    logic [15:0] lerr_cnt;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  uart_frame_rx_deframer_top #(.BUFFER_DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // deframer shadow state
  logic [7:0]  rx_bytes [DEPTH];
  int          rx_fill;
  bit          lost_flag;
  logic [7:0]  tick_now;
  logic [7:0]  tick_last_byte;
  logic [15:0] crc_fail_cnt;
  logic [15:0] ovf_cnt;
  logic [15:0] lerr_cnt;
  logic [7:0]  cfg_timeout;
  logic [7:0]  cfg_pre1;
  logic [7:0]  cfg_pre2;

  frame_result_t pending_results[$];
  int  error_count;
  int  sender_idle_pct;
  int  rx_stall_pct;
  int  rx_hold_cycles;
  int  quiet_cycles;
  int  items_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] crc_next(logic [7:0] c, logic [7:0] d);
    logic [7:0] x;
    x = c ^ d;
    for (int b = 0; b < 8; b++) x = x[0] ? ((x >> 1) ^ 8'h8C) : (x >> 1);
    return x;
  endfunction

  function automatic void drop_bytes(int n);
    if (n > rx_fill) return;
    rx_fill -= n;
    for (int i = 0; i < rx_fill; i++) rx_bytes[i] = rx_bytes[i + n];
  endfunction

  function automatic void push_result(logic [7:0] code, logic [7:0] d, logic has,
                                      int idx, logic last);
    frame_result_t r;
    r.code = code; r.data = d; r.has = has; r.idx = idx[5:0]; r.last = last;
    r.crc_cnt = crc_fail_cnt; r.ovf_cnt = ovf_cnt; r.lerr_cnt = lerr_cnt;
    pending_results.push_back(r);
  endfunction

  function automatic void scan_buffer();
    int nres, pos, len, nd, need;
    logic [7:0] c;
    nres = 0;
    if (lost_flag) begin
      rx_fill = 0;
      lost_flag = 1'b0;
      return;
    end
    while (rx_fill > 1) begin
      pos = rx_fill - 1;
      for (int i = 0; i + 1 < rx_fill; i++) begin
        if (rx_bytes[i] == cfg_pre1 && rx_bytes[i + 1] == cfg_pre2) begin
          pos = i;
          break;
        end
      end
      if (pos != 0) drop_bytes(pos);
      if (rx_fill >= 5) begin
        len = int'(rx_bytes[2]);
        if (len < 3 || len > DEPTH - 2) begin
          drop_bytes(2);
          continue;
        end
        if (rx_fill >= len + 2) begin
          c = 8'h00;
          for (int i = 0; i < len - 1; i++) c = crc_next(c, rx_bytes[2 + i]);
          if (c == rx_bytes[len + 1]) begin
            nd = len - 3;
            need = (nd != 0) ? nd : 1;
            if (nres + need > int'(ufd_pkg::MAX_RESULTS)) break;
            if (nd == 0) push_result(rx_bytes[3], 8'h00, 1'b0, 0, 1'b1);
            else for (int i = 0; i < nd; i++)
              push_result(rx_bytes[3], rx_bytes[4 + i], 1'b1, i, i + 1 == nd);
            nres += need;
            drop_bytes(len + 2);
          end else begin
            crc_fail_cnt++;
            drop_bytes(2);
          end
          continue;
        end
      end
      if (8'(tick_now - tick_last_byte) >= cfg_timeout) begin
        drop_bytes(2);
        continue;
      end
      break;
    end
  endfunction

  function automatic void predict_item(bit kind, logic [7:0] b, bit lerr);
    if (kind == KIND_BYTE) begin
      tick_last_byte = tick_now;
      if (lerr) begin
        lerr_cnt++;
        lost_flag = 1'b1;
      end else if (rx_fill < DEPTH) begin
        rx_bytes[rx_fill++] = b;
      end else begin
        lost_flag = 1'b1;
        ovf_cnt++;
      end
    end else begin
      tick_now++;
    end
    scan_buffer();
  endfunction

  task automatic send_item(bit kind, logic [7:0] b, bit lerr);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, lerr, b};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    predict_item(kind, b, lerr);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(KIND_BYTE, b, 1'b0);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(KIND_TICK, 8'($urandom), 1'b0);
  endtask

  // bad_crc flips the check byte; len_override forces the length byte
  task automatic send_frame(logic [7:0] code, int nd, bit bad_crc = 1'b0,
                            int len_override = -1);
    logic [7:0] len, c, d;
    len = (len_override >= 0) ? 8'(len_override) : 8'(nd + 3);
    send_byte(cfg_pre1);
    send_byte(cfg_pre2);
    send_byte(len);
    c = crc_next(8'h00, len);
    send_byte(code);
    c = crc_next(c, code);
    for (int i = 0; i < nd; i++) begin
      d = 8'($urandom);
      send_byte(d);
      c = crc_next(c, d);
    end
    send_byte(bad_crc ? ~c : c);
  endtask

  // hold until every result is out and the block is back to idle
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 || !s_axis_tready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ufd_pkg::reg_idx_t idx, logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      ufd_pkg::REG_TIMEOUT: cfg_timeout = value;
      ufd_pkg::REG_PRE1:    cfg_pre1 = value;
      default:              cfg_pre2 = value;
    endcase
  endtask

  always @(posedge clk) begin
    frame_result_t exp_r, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[16], m_axis_tdata[22:17],
             m_axis_tlast, m_axis_tdata[38:23], m_axis_tdata[54:39], m_axis_tdata[70:55]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer %h last %b", $time, m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.code !== exp_r.code)
          $display("%0t: msg_code exp %h got %h", $time, exp_r.code, got.code);
        if (got.data !== exp_r.data)
          $display("%0t: data_byte exp %h got %h", $time, exp_r.data, got.data);
        if (got.has !== exp_r.has)
          $display("%0t: has_data exp %b got %b", $time, exp_r.has, got.has);
        if (got.idx !== exp_r.idx)
          $display("%0t: data_index exp %0d got %0d", $time, exp_r.idx, got.idx);
        if (got.last !== exp_r.last)
          $display("%0t: last exp %b got %b", $time, exp_r.last, got.last);
        if (got.crc_cnt !== exp_r.crc_cnt)
          $display("%0t: crc_error_count exp %0d got %0d", $time, exp_r.crc_cnt, got.crc_cnt);
        if (got.ovf_cnt !== exp_r.ovf_cnt)
          $display("%0t: overflow_count exp %0d got %0d", $time, exp_r.ovf_cnt, got.ovf_cnt);
        if (got.lerr_cnt !== exp_r.lerr_cnt)
          $display("%0t: line_error_count exp %0d got %0d", $time, exp_r.lerr_cnt,
                   got.lerr_cnt);
        if (got !== exp_r || m_axis_tdata[71] !== 1'b0) error_count++;
      end
    end
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("tb_uart_frame_rx_deframer_top: done, errors");
      $finish;
    end
  end

  task automatic test_basic_frames();
    send_frame(8'h00, 0);
    send_frame(8'hFF, 1);
    send_byte(8'h55);                 // noise ahead of the preamble
    send_byte(cfg_pre1);
    send_frame(8'hA5, DEPTH - 5);     // longest frame the buffer holds
    wait_drain();
  endtask

  task automatic test_error_paths();
    send_frame(8'h11, 2, 1'b1);       // bad check byte
    send_frame(8'h12, 0, 1'b0, 2);    // length too short
    send_frame(8'h13, 0, 1'b0, DEPTH - 1);  // length too long
    send_frame(8'h14, 0, 1'b0, 255);
    send_byte(cfg_pre1);
    send_byte(cfg_pre2);
    send_item(KIND_BYTE, 8'hFF, 1'b1);  // line error mid-frame
    send_frame(8'h15, 2);
    send_byte(cfg_pre1);              // lone first byte, then completed
    send_frame(8'h16, 1);
    wait_drain();
  endtask

  task automatic test_idle_timeout();
    write_reg(ufd_pkg::REG_TIMEOUT, 8'd3);
    send_byte(cfg_pre1);
    send_byte(cfg_pre2);
    send_byte(8'd6);
    send_byte(8'h21);
    send_ticks(3);
    send_byte(8'h00);
    send_frame(8'h22, 2);
    send_ticks(2);
    send_frame(8'h23, 1);
    wait_drain();
  endtask

  task automatic test_register_sweep();
    write_reg(ufd_pkg::REG_TIMEOUT, 8'd255);
    write_reg(ufd_pkg::REG_PRE1, 8'h00);
    write_reg(ufd_pkg::REG_PRE2, 8'hFF);
    send_frame(8'h31, 2);
    send_ticks(5);
    send_frame(8'h32, 0);
    wait_drain();
    write_reg(ufd_pkg::REG_PRE1, 8'hFF);
    write_reg(ufd_pkg::REG_PRE2, 8'hFF);
    write_reg(ufd_pkg::REG_TIMEOUT, 8'd1);
    send_frame(8'h33, 1);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_ticks(1);
    send_frame(8'h34, 1);
    wait_drain();
    write_reg(ufd_pkg::REG_PRE1, ufd_pkg::TIMEOUT_RESET ^ 8'h5C);
    write_reg(ufd_pkg::REG_PRE2, 8'h3A);
    write_reg(ufd_pkg::REG_TIMEOUT, 8'd5);
    wait_drain();
  endtask

  task automatic send_random_sequence();
    int sel, nd;
    sel = int'($urandom_range(99));
    nd  = int'($urandom_range(0, 6));
    if (sel < 65) begin
      send_frame(8'($urandom), nd);
      if ($urandom_range(3) == 0) send_ticks(int'($urandom_range(1, 3)));
    end else if (sel < 73) begin
      send_frame(8'($urandom), nd, 1'b1);
    end else if (sel < 79) begin
      send_frame(8'($urandom), 0, 1'b0,
                 ($urandom_range(1) != 0) ? int'($urandom_range(0, 2))
                                          : int'($urandom_range(DEPTH - 1, 255)));
    end else if (sel < 85) begin
      send_byte(cfg_pre1);
      send_byte(cfg_pre2);
      send_byte(8'(nd + 3));
      send_ticks(int'(cfg_timeout) + int'($urandom_range(0, 2)));
    end else if (sel < 91) begin
      send_byte(cfg_pre1);
      send_byte(cfg_pre2);
      send_item(KIND_BYTE, 8'($urandom), 1'b1);
    end else begin
      repeat ($urandom_range(1, 5))
        send_item(1'($urandom_range(1)), 8'($urandom), ($urandom_range(7) == 0));
    end
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int items);
    int start_count;
    sender_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    start_count = items_sent;
    while (items_sent - start_count < items) send_random_sequence();
    wait_drain();
    sender_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    rx_hold_cycles = 1500;
    repeat (3) send_frame(8'($urandom), int'($urandom_range(3, 6)));
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rx_fill = 0;
    lost_flag = 1'b0;
    tick_now = '0;
    tick_last_byte = '0;
    crc_fail_cnt = '0;
    ovf_cnt = '0;
    lerr_cnt = '0;
    cfg_timeout = ufd_pkg::TIMEOUT_RESET;
    cfg_pre1 = ufd_pkg::PRE1_RESET;
    cfg_pre2 = ufd_pkg::PRE2_RESET;
    error_count = 0;
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_cycles = 0;
    quiet_cycles = 0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    test_basic_frames();
    test_error_paths();
    test_idle_timeout();
    test_register_sweep();
    test_random_phase(0, 0, 8);
    test_random_phase(57, 0, 8);
    test_random_phase(0, 57, 8);
    test_random_phase(31, 31, 8);
    test_backpressure();
    write_reg(ufd_pkg::REG_PRE1, ufd_pkg::PRE1_RESET);
    write_reg(ufd_pkg::REG_PRE2, ufd_pkg::PRE2_RESET);
    write_reg(ufd_pkg::REG_TIMEOUT, 8'd2);
    test_random_phase(31, 31, 6);

    if (error_count == 0 && pending_results.size() == 0)
      $display("tb_uart_frame_rx_deframer_top: done, clean");
    else
      $display("tb_uart_frame_rx_deframer_top: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ufd_pkg.sv
hdl/uart_frame_rx_deframer_top.sv
test/tb_uart_frame_rx_deframer_top.sv
